[hdl/fenwick_tree_range_sum_macros.svh]
// Assertion macros shared by the Fenwick tree range-sum block.
`ifndef FENWICK_TREE_RANGE_SUM_MACROS_SVH
`define FENWICK_TREE_RANGE_SUM_MACROS_SVH

`ifndef NO_ASSERTIONS

// A condition that holds at every clock edge outside reset.
`define FTRS_CHECK(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// A condition that implies another at the same edge.
`define FTRS_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// A condition that implies another at the following edge.
`define FTRS_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define FTRS_CHECK(lbl, cond, msg)
`define FTRS_IMPLY(lbl, ante, cons, msg)
`define FTRS_NEXT(lbl, ante, cons, msg)

`endif

`endif

[hdl/ftrs_pkg.sv]
// Package with the types, constants and helper functions of the Fenwick tree block.
package ftrs_pkg;

	localparam int TABLE_SIZE = 1024;
	localparam int ADDR_W     = $clog2(TABLE_SIZE);
	// Walk position: holds up to twice the table size during an upward walk.
	localparam int K_W        = ADDR_W + 2;

	localparam int ACTION_W = 2;
	localparam int INDEX_W  = 10;
	localparam int BOUND_W  = 11;
	localparam int DATA_W   = 32;

	localparam logic [ACTION_W-1:0] ACT_ADD   = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_RANGE = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;
	localparam logic [ACTION_W-1:0] ACT_SET   = 2'd3;

	typedef enum logic [2:0] {
		FT_CLEAR,
		FT_IDLE,
		FT_WALK_HI,
		FT_WALK_LO,
		FT_DRAIN,
		FT_ADD,
		FT_EMIT
	} ft_state_t;

	typedef enum logic [1:0] {
		RK_PLUS,
		RK_MINUS,
		RK_UPD
	} rd_kind_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [DATA_W-1:0] wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} ram_req_t;

	// Lowest set bit of a walk position.
	function automatic logic [K_W-1:0] low_bit(input logic [K_W-1:0] x);
		return x & (~x + K_W'(1));
	endfunction

	// Prefix bound, saturated to the table size.
	function automatic logic [K_W-1:0] sat_bound(input logic [31:0] b);
		logic [K_W-1:0] r;
		if (b > 32'(TABLE_SIZE))
			r = K_W'(TABLE_SIZE);
		else
			r = K_W'(b);
		return r;
	endfunction

	// First node of an upward walk; past the table it starts beyond the end and does nothing.
	function automatic logic [K_W-1:0] add_start(input logic [31:0] p1);
		logic [K_W-1:0] r;
		if (p1 > 32'(TABLE_SIZE))
			r = K_W'(TABLE_SIZE + 1);
		else
			r = K_W'(p1);
		return r;
	endfunction

endpackage

[hdl/ftrs_ram.sv]
// Partial-sum memory with one write port and one registered read port.
module ftrs_ram (
	input  logic                          clk,
	input  ftrs_pkg::ram_req_t            req,
	output logic [ftrs_pkg::DATA_W-1:0]   rd_data
);
	import ftrs_pkg::*;

	logic [DATA_W-1:0] mem [TABLE_SIZE];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.we)
			mem[req.waddr] <= req.wdata;
		if (req.re)
			rdata_q <= mem[req.raddr];
	end

	assign rd_data = rdata_q;

endmodule

[hdl/ftrs_engine.sv]
// Sequencer that walks the Fenwick tree in memory for each incoming word.
`include "fenwick_tree_range_sum_macros.svh"

module ftrs_engine (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [ftrs_pkg::ACTION_W-1:0]   action,
	input  logic [ftrs_pkg::INDEX_W-1:0]    index,
	input  logic [ftrs_pkg::BOUND_W-1:0]    right_bound,
	input  logic [ftrs_pkg::DATA_W-1:0]     value,
	output logic                            res_valid,
	input  logic                            res_ready,
	output logic [ftrs_pkg::DATA_W-1:0]     res_total,
	output ftrs_pkg::ram_req_t              ram_req,
	input  logic [ftrs_pkg::DATA_W-1:0]     rd_data
);
	import ftrs_pkg::*;

	ft_state_t state_q, state_d;
	logic [ADDR_W-1:0] clr_q;

	logic [K_W-1:0]      k_q, k_d;
	logic [K_W-1:0]      lo_q, lo_d;
	logic [K_W-1:0]      idx_q, idx_d;
	logic [ACTION_W-1:0] act_q, act_d;
	logic [DATA_W-1:0]   amt_q, amt_d;
	logic [DATA_W-1:0]   val_q, val_d;
	logic [DATA_W-1:0]   acc_q, acc_d;

	logic              rd_v_s1;
	rd_kind_t          kind_s1;
	logic [ADDR_W-1:0] addr_s1;

	logic        rd_issue;
	rd_kind_t    kind_d;
	logic [K_W-1:0] k_minus;

	assign k_minus = k_q - K_W'(1);

	always_comb begin
		state_d  = state_q;
		k_d      = k_q;
		lo_d     = lo_q;
		idx_d    = idx_q;
		act_d    = act_q;
		amt_d    = amt_q;
		val_d    = val_q;
		acc_d    = acc_q;
		rd_issue = 1'b0;
		kind_d   = RK_PLUS;
		in_stall = (state_q != FT_IDLE);
		res_valid = 1'b0;

		// Read data of the previous cycle's node folds into the running sum on a query walk.
		if (rd_v_s1) begin
			case (kind_s1)
				RK_PLUS:  acc_d = acc_q + rd_data;
				RK_MINUS: acc_d = acc_q - rd_data;
				default:  ;
			endcase
		end

		case (state_q)
			FT_CLEAR: begin
				if (clr_q == ADDR_W'(TABLE_SIZE - 1))
					state_d = FT_IDLE;
			end
			FT_IDLE: begin
				if (in_valid) begin
					act_d = action;
					val_d = value;
					amt_d = value;
					acc_d = '0;
					idx_d = add_start(32'(index) + 32'd1);
					case (action)
						ACT_ADD: begin
							k_d     = add_start(32'(index) + 32'd1);
							state_d = FT_ADD;
						end
						ACT_RANGE: begin
							k_d     = sat_bound(32'(right_bound));
							lo_d    = sat_bound(32'(index));
							state_d = FT_WALK_HI;
						end
						default: begin
							k_d     = sat_bound(32'(index) + 32'd1);
							lo_d    = sat_bound(32'(index));
							state_d = FT_WALK_HI;
						end
					endcase
				end
			end
			FT_WALK_HI: begin
				if (k_q != '0) begin
					rd_issue = 1'b1;
					kind_d   = RK_PLUS;
					k_d      = k_q - low_bit(k_q);
				end else begin
					k_d     = lo_q;
					state_d = FT_WALK_LO;
				end
			end
			FT_WALK_LO: begin
				if (k_q != '0) begin
					rd_issue = 1'b1;
					kind_d   = RK_MINUS;
					k_d      = k_q - low_bit(k_q);
				end else begin
					state_d = FT_DRAIN;
				end
			end
			FT_DRAIN: begin
				if (!rd_v_s1) begin
					if (act_q == ACT_SET) begin
						amt_d   = val_q - acc_q;
						k_d     = idx_q;
						state_d = FT_ADD;
					end else begin
						state_d = FT_EMIT;
					end
				end
			end
			FT_ADD: begin
				if (k_q <= K_W'(TABLE_SIZE)) begin
					rd_issue = 1'b1;
					kind_d   = RK_UPD;
					k_d      = k_q + low_bit(k_q);
				end else begin
					state_d = FT_IDLE;
				end
			end
			FT_EMIT: begin
				res_valid = 1'b1;
				if (res_ready)
					state_d = FT_IDLE;
			end
			default: state_d = FT_IDLE;
		endcase
	end

	always_comb begin
		ram_req.re    = rd_issue;
		ram_req.raddr = k_minus[ADDR_W-1:0];
		if (state_q == FT_CLEAR) begin
			ram_req.we    = 1'b1;
			ram_req.waddr = clr_q;
			ram_req.wdata = '0;
		end else begin
			ram_req.we    = rd_v_s1 && (kind_s1 == RK_UPD);
			ram_req.waddr = addr_s1;
			ram_req.wdata = rd_data + amt_q;
		end
	end

	assign res_total = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FT_CLEAR;
			clr_q   <= '0;
			rd_v_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_v_s1 <= rd_issue;
			if (state_q == FT_CLEAR)
				clr_q <= clr_q + ADDR_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		k_q     <= k_d;
		lo_q    <= lo_d;
		idx_q   <= idx_d;
		act_q   <= act_d;
		amt_q   <= amt_d;
		val_q   <= val_d;
		acc_q   <= acc_d;
		kind_s1 <= kind_d;
		addr_s1 <= k_minus[ADDR_W-1:0];
	end

	`FTRS_IMPLY(a_clear_alone, state_q == FT_CLEAR, !(rd_v_s1 && kind_s1 == RK_UPD), "update write during clearing pass")
	`FTRS_IMPLY(a_no_same_entry, rd_v_s1 && kind_s1 == RK_UPD && ram_req.re, ram_req.raddr != addr_s1, "read of an entry whose update is in flight")
	`FTRS_NEXT(a_acc_cleared, state_q == FT_IDLE && in_valid, acc_q == '0, "sum not cleared on a new word")
	`FTRS_IMPLY(a_res_drained, res_valid, !rd_v_s1, "result shown before the last read was folded in")

endmodule

[hdl/fenwick_tree_range_sum.sv]
// Top level of the Fenwick tree range-sum block with its output register.
//
// The block keeps 1024 signed 32-bit entries as Fenwick partial sums in one
// synchronous memory. An input word carries an action (point add, range sum,
// point read, point set), an index, an exclusive right bound and a value.
// Range sum and point read each give one output word, total; point add and
// point set give none. Sums wrap modulo 2^32.
// Both channels use valid and stall; a word moves at an edge where valid is
// high and stall is low. One input word is worked on at a time: each walk of
// the tree issues one memory read a cycle, and an update writes each node back
// in the cycle after its read. A range sum or point read walks both prefixes;
// a point set walks both, then makes the upward walk that a point add makes.
// The result reaches total through the output register.
// After reset the memory is cleared one entry a cycle while in_stall stays
// high. If the receiver stalls, the result waits in the output register; the
// next input word is still taken, and only its own result is held back until
// the register is free.
module fenwick_tree_range_sum (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic        [ftrs_pkg::ACTION_W-1:0] action,
	input  logic        [ftrs_pkg::INDEX_W-1:0]  index,
	input  logic        [ftrs_pkg::BOUND_W-1:0]  right_bound,
	input  logic signed [ftrs_pkg::DATA_W-1:0]   value,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [ftrs_pkg::DATA_W-1:0]   total
);
	import ftrs_pkg::*;

	ram_req_t          ram_req;
	logic [DATA_W-1:0] rd_data;
	logic              res_valid;
	logic              res_ready;
	logic [DATA_W-1:0] res_total;

	logic              out_valid_q;
	logic [DATA_W-1:0] total_q;

	ftrs_ram u_ram (
		.clk     (clk),
		.req     (ram_req),
		.rd_data (rd_data)
	);

	ftrs_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.action      (action),
		.index       (index),
		.right_bound (right_bound),
		.value       (value),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res_total   (res_total),
		.ram_req     (ram_req),
		.rd_data     (rd_data)
	);

	// The output register takes a new result when it is empty or being emptied.
	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready)
			total_q <= res_total;
	end

	assign out_valid = out_valid_q;
	assign total     = total_q;

endmodule

[bench/tb.sv]
// Self-checking bench for the Fenwick tree range-sum block: random traffic, own predictor.
`timescale 1ns / 1ps

module tb;

	import ftrs_pkg::*;

	// A cycle limit with nothing moving on either channel. It covers the clearing pass after
	// reset, the long receiver hold-off and the slowest point set.
	localparam int WATCHDOG_LIMIT = 4000;
	// The receiver's one long hold-off, in cycles.
	localparam int LONG_HOLD      = 300;
	// Quiet cycles after the last total; a point set is the slowest action.
	localparam int SETTLE_CYCLES  = 64;
	localparam int RANDOM_WORDS   = 400;

	typedef struct {
		logic [ACTION_W-1:0] act;
		logic [INDEX_W-1:0]  idx;
		logic [BOUND_W-1:0]  rb;
		logic [DATA_W-1:0]   val;
	} in_word_t;

	// How willing the receiver is to take totals during one stretch.
	typedef enum logic [1:0] {
		RX_FREE,
		RX_HALF,
		RX_LIGHT,
		RX_HEAVY
	} rx_mode_t;

	logic                       clk         = 1'b0;
	logic                       arst_n      = 1'b0;
	logic                       in_valid    = 1'b0;
	logic                       in_stall;
	logic        [ACTION_W-1:0] action      = ACT_ADD;
	logic        [INDEX_W-1:0]  index       = '0;
	logic        [BOUND_W-1:0]  right_bound = '0;
	logic signed [DATA_W-1:0]   value       = '0;
	logic                       out_valid;
	logic                       out_stall   = 1'b0;
	logic signed [DATA_W-1:0]   total;

	fenwick_tree_range_sum dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.action      (action),
		.index       (index),
		.right_bound (right_bound),
		.value       (value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.total       (total)
	);

	// The clock runs at 8 ns, high half first after the opening low half.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Reset is held at the start and then released for good.
	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	// ------------------------------------------------------------------
	// Predictor state. The bench keeps the plain entry values rather than the tree's
	// partial sums: a prefix is then just a running sum, which checks the block's walks
	// against an independent formulation.
	// ------------------------------------------------------------------
	logic        [DATA_W-1:0] entries [TABLE_SIZE];
	logic signed [DATA_W-1:0] expected_totals [$];
	in_word_t                 pending_words [$];

	int errors         = 0;
	int totals_checked = 0;
	int adds_seen      = 0;
	int ranges_seen    = 0;
	int reads_seen     = 0;
	int sets_seen      = 0;

	// Sum of entries 0 .. bound-1, wrapped to 32 bits. A bound past the table is clipped
	// to the table size, which is how the block treats an oversized right bound.
	function automatic logic [DATA_W-1:0] prefix_total(input int unsigned bound);
		logic [DATA_W-1:0] acc;
		int unsigned       lim;
		acc = '0;
		lim = (bound > TABLE_SIZE) ? TABLE_SIZE : bound;
		for (int unsigned k = 0; k < lim; k++)
			acc += entries[k];
		return acc;
	endfunction

	// Applies one accepted input word to the predictor. Range sums and point reads leave
	// a total to be matched; adds and sets only change the entries.
	function automatic void apply_word(input logic [ACTION_W-1:0] act,
			input logic [INDEX_W-1:0] idx, input logic [BOUND_W-1:0] rb,
			input logic [DATA_W-1:0] val);
		case (act)
			ACT_ADD: begin
				entries[idx] += val;
				adds_seen++;
			end
			ACT_RANGE: begin
				// A reversed range gives the negated sum; an empty one gives zero.
				expected_totals.push_back(prefix_total(32'(rb)) - prefix_total(32'(idx)));
				ranges_seen++;
			end
			ACT_READ: begin
				expected_totals.push_back(entries[idx]);
				reads_seen++;
			end
			default: begin
				entries[idx] = val;
				sets_seen++;
			end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Driver. Words leave the pending queue in bursts of random length separated by
	// random gaps. A stalled word is held unchanged; the word is handed to the predictor
	// at the edge where the block takes it, using the values still on the ports.
	// ------------------------------------------------------------------
	int burst_left = 0;
	int gap_left   = 0;

	always @(posedge clk) begin : word_driver
		in_word_t w;
		logic     offer;
		if (!arst_n) begin
			foreach (entries[k])
				entries[k] = '0;
			in_valid   <= 1'b0;
			burst_left <= 0;
			gap_left   <= 0;
		end else begin
			if (in_valid && !in_stall)
				apply_word(action, index, right_bound, value);
			if (!(in_valid && in_stall)) begin
				offer = 1'b0;
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
				end else if (pending_words.size() != 0) begin
					w           = pending_words.pop_front();
					action      <= w.act;
					index       <= w.idx;
					right_bound <= w.rb;
					value       <= w.val;
					offer       = 1'b1;
					if (burst_left <= 1) begin
						// About a third of the bursts run straight into the next one.
						burst_left <= $urandom_range(1, 24);
						gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
					end else begin
						burst_left <= burst_left - 1;
					end
				end
				in_valid <= offer;
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver. It switches between stall patterns in stretches of random length, from taking
	// every total to stalling most of the time. Once, well into the random traffic, it
	// holds off for a long stretch so that the output register fills, the next word's
	// total is held back, and the block has to stall its input.
	// ------------------------------------------------------------------
	rx_mode_t rx_mode        = RX_FREE;
	int       rx_phase_left  = 0;
	int       hold_left      = 0;
	int       rx_totals_seen = 0;
	logic     long_hold_done = 1'b0;

	always @(posedge clk) begin : total_receiver
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall)
				rx_totals_seen <= rx_totals_seen + 1;
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_stall <= 1'b1;
			end else if (!long_hold_done && rx_totals_seen >= 60) begin
				long_hold_done <= 1'b1;
				hold_left      <= LONG_HOLD - 1;
				out_stall      <= 1'b1;
			end else begin
				if (rx_phase_left == 0) begin
					rx_mode       <= rx_mode_t'($urandom_range(0, 3));
					rx_phase_left <= $urandom_range(16, 96);
				end else begin
					rx_phase_left <= rx_phase_left - 1;
				end
				case (rx_mode)
					RX_FREE:  out_stall <= 1'b0;
					RX_HALF:  out_stall <= ($urandom_range(0, 1) == 0);
					RX_LIGHT: out_stall <= ($urandom_range(0, 4) == 0);
					default:  out_stall <= ($urandom_range(0, 4) != 0);
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor. Each total taken is matched against the oldest expectation.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : total_monitor
		logic signed [DATA_W-1:0] want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_totals.size() == 0) begin
				$display("%0t: total %0d arrived with none expected", $time, total);
				errors++;
			end else begin
				want = expected_totals.pop_front();
				totals_checked++;
				if (total !== want) begin
					$display("%0t: total mismatch: expected %0d, actual %0d",
						$time, want, total);
					errors++;
				end
			end
		end
	end

	// Watchdog: ends the run if neither channel moves a word for too long.
	int idle_cycles = 0;

	always @(posedge clk) begin : watchdog
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("%0t: no word moved for %0d cycles, %0d totals still expected",
				$time, WATCHDOG_LIMIT, expected_totals.size());
			$display("[fenwick_tree_range_sum] ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	task automatic queue_word(input logic [ACTION_W-1:0] act, input int unsigned idx,
			input int unsigned rb, input logic [DATA_W-1:0] val);
		in_word_t w;
		w.act = act;
		w.idx = idx[INDEX_W-1:0];
		w.rb  = rb[BOUND_W-1:0];
		w.val = val;
		pending_words.push_back(w);
	endtask

	// Sampled on the falling edge, so the driver's and monitor's work at the rising edge
	// has settled. Used for the mid-run pause and before the end of the run.
	task automatic wait_drained;
		do
			@(negedge clk);
		while (pending_words.size() != 0 || in_valid || expected_totals.size() != 0);
	endtask

	initial begin : stimulus
		logic [ACTION_W-1:0] act;
		int unsigned         idx;
		int unsigned         rb;
		logic [DATA_W-1:0]   val;

		// Directed part. The right bound of most point actions is random, as the block must
		// ignore it there.
		queue_word(ACT_RANGE, 0, TABLE_SIZE, $urandom);              // whole table, empty
		queue_word(ACT_ADD, 0, $urandom_range(0, 2047), 32'h7fff_ffff);
		queue_word(ACT_ADD, 1023, $urandom_range(0, 2047), 32'h8000_0000);
		queue_word(ACT_ADD, 0, $urandom_range(0, 2047), 32'h0000_0001); // wraps entry 0
		queue_word(ACT_READ, 0, $urandom_range(0, 2047), $urandom);
		queue_word(ACT_READ, 1023, $urandom_range(0, 2047), $urandom);
		queue_word(ACT_RANGE, 0, TABLE_SIZE, $urandom);
		queue_word(ACT_RANGE, 0, 2047, $urandom);                    // bound clipped
		queue_word(ACT_RANGE, 1023, 1500, $urandom);                 // last entry, clipped
		queue_word(ACT_RANGE, 5, 5, $urandom);                       // empty range
		queue_word(ACT_SET, 512, $urandom_range(0, 2047), 32'd12345);
		queue_word(ACT_SET, 512, $urandom_range(0, 2047), 32'hffff_ffff);
		queue_word(ACT_READ, 512, $urandom_range(0, 2047), $urandom);
		queue_word(ACT_SET, 0, $urandom_range(0, 2047), 32'h0000_0000);
		queue_word(ACT_RANGE, 0, 1, $urandom);
		queue_word(ACT_ADD, 341, 1365, 32'h5555_5555);               // alternating bits
		queue_word(ACT_ADD, 682, 682, 32'haaaa_aaaa);
		queue_word(ACT_RANGE, 341, 683, $urandom);
		queue_word(ACT_RANGE, 1000, 3, $urandom);                    // reversed range
		queue_word(ACT_RANGE, 0, 0, $urandom);
		queue_word(ACT_RANGE, 1023, 2047, $urandom);
		queue_word(ACT_READ, 682, $urandom_range(0, 2047), $urandom);

		// The sender pauses here until every expected total has come back.
		wait_drained();

		// Random part. Indices cluster at both ends of the table so that updates and
		// queries keep meeting the same entries and tree nodes.
		repeat (RANDOM_WORDS) begin
			act = ACTION_W'($urandom_range(0, 3));
			case ($urandom_range(0, 5))
				0, 1:    idx = $urandom_range(0, 15);
				2:       idx = $urandom_range(1008, 1023);
				3:       idx = (1 << $urandom_range(0, 9)) - $urandom_range(0, 1);
				default: idx = $urandom_range(0, 1023);
			endcase
			case ($urandom_range(0, 7))
				0:       rb = idx;
				1:       rb = idx + $urandom_range(1, 16);
				2:       rb = $urandom_range(TABLE_SIZE + 1, 2047);
				3:       rb = TABLE_SIZE;
				4:       rb = $urandom_range(0, 15);
				default: rb = $urandom_range(0, TABLE_SIZE);
			endcase
			case ($urandom_range(0, 5))
				0:       val = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
				1:       val = 32'($urandom_range(0, 20)) - 32'd10;
				default: val = $urandom;
			endcase
			queue_word(act, idx, rb, val);
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("Covered %0d point adds, %0d range sums, %0d point reads, %0d point sets.",
			adds_seen, ranges_seen, reads_seen, sets_seen);
		$display("Checked %0d totals, with one receiver hold-off of %0d cycles.",
			totals_checked, LONG_HOLD);
		if (errors == 0 && expected_totals.size() == 0)
			$display("[fenwick_tree_range_sum] OK");
		else
			$display("[fenwick_tree_range_sum] ERROR");
		$finish;
	end

endmodule

[files.f]
+incdir+hdl
hdl/ftrs_pkg.sv
hdl/ftrs_ram.sv
hdl/ftrs_engine.sv
hdl/fenwick_tree_range_sum.sv
bench/tb.sv
